>>> src/bfa_pkg.sv
// ----------------------------------------------------------------------------
// bfa_pkg
// Shared constants and codes of the bitmap page-frame allocator.
// ----------------------------------------------------------------------------
package bfa_pkg;

  // Bitmap geometry
  localparam int BITMAP_WORDS = 1024;
  localparam int WORD_BITS    = 32;
  localparam int WORD_AW      = $clog2(BITMAP_WORDS);
  localparam int BIT_W        = $clog2(WORD_BITS);
  localparam int FRAME_W      = 15;
  localparam int COUNT_W      = 16;
  localparam int LIMIT_W      = 11;
  localparam int ACTION_W     = 2;

  localparam logic [WORD_BITS-1:0] FULL_WORD = {WORD_BITS{1'b1}};
  localparam logic [COUNT_W-1:0]   COUNT_MAX = {COUNT_W{1'b1}};
  localparam logic [LIMIT_W-1:0]   LIMIT_MAX = LIMIT_W'(BITMAP_WORDS);
  localparam logic [WORD_AW-1:0]   HINT_RESET = WORD_AW'(1);

  // Stream word widths, fields packed from bit 0 up, padded to bytes
  localparam int IN_BITS  = ACTION_W + FRAME_W + WORD_AW + WORD_BITS;
  localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS = 1 + FRAME_W + COUNT_W;
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

  typedef enum logic [ACTION_W-1:0] {
    ACT_ALLOC = 2'd0,
    ACT_MARK  = 2'd1,
    ACT_FREE  = 2'd2,
    ACT_LOAD  = 2'd3
  } action_t;

endpackage

>>> src/bfa_ram.sv
// ----------------------------------------------------------------------------
// bfa_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module bfa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> src/bitmap_frame_allocator.sv
// ----------------------------------------------------------------------------
// bitmap_frame_allocator
// Page-frame allocator over a 1024 x 32-bit bitmap held in one RAM.
// ----------------------------------------------------------------------------
// Load writes the word when it is accepted; mark/free pass through a read-modify-
//   write state; allocate reads bitmap words from the hint until a free bit or the limit.
// One word at a time: the next word is taken only once the last result is
//   registered, and that waits while a held result meets m_tready low.
// Reset: synchronous, active high; then a pass writes every bitmap word to all
//   ones, with s_tready low. Configuration writes are taken whenever not in reset.
module bitmap_frame_allocator (
  input  logic                         clk,
  input  logic                         rst,
  // input word: action[1:0], frame_number[16:2], word_index[26:17],
  // word_value[58:27], zero padding[63:59]
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [bfa_pkg::IN_W-1:0]     s_tdata,
  // result word: ok[0], found_frame[15:1], allocated_count[31:16]
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [bfa_pkg::OUT_W-1:0]    m_tdata,
  // configuration: words_in_use
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [bfa_pkg::LIMIT_W-1:0]  cfg_data
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RMW,
    ST_SCAN,
    ST_RESP
  } state_t;

  localparam int AW = bfa_pkg::WORD_AW;
  localparam int BW = bfa_pkg::BIT_W;
  localparam int WB = bfa_pkg::WORD_BITS;
  localparam int LW = bfa_pkg::LIMIT_W;

  // Input word fields
  logic [bfa_pkg::ACTION_W-1:0] in_action;
  logic [bfa_pkg::FRAME_W-1:0]  in_frame;
  logic [AW-1:0]                in_widx;
  logic [WB-1:0]                in_wval;

  assign in_action = s_tdata[1:0];
  assign in_frame  = s_tdata[16:2];
  assign in_widx   = s_tdata[26:17];
  assign in_wval   = s_tdata[58:27];

  // State and registers
  state_t                       state;
  logic [AW-1:0]                clr_addr;
  logic [LW-1:0]                words_in_use;
  logic [AW-1:0]                search_hint;
  logic [bfa_pkg::COUNT_W-1:0]  used_count;
  bfa_pkg::action_t             act;
  logic [bfa_pkg::FRAME_W-1:0]  frame;
  logic [LW-1:0]                cur;
  logic                         res_ok;
  logic [bfa_pkg::FRAME_W-1:0]  res_found;

  // RAM ports
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [WB-1:0] ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [WB-1:0] ram_rdata;

  bfa_ram #(
    .WIDTH (WB),
    .DEPTH (bfa_pkg::BITMAP_WORDS)
  ) u_bitmap (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Helpers
  logic          accept;
  logic [LW-1:0] limit;
  logic [LW-1:0] cur_next;
  logic [AW-1:0] frame_word;
  logic [WB-1:0] frame_bit;
  logic [WB-1:0] free_onehot;
  logic [BW-1:0] free_idx;
  logic          word_full;
  logic          out_free;

  assign s_tready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;

  // Clamp the search limit to the bitmap size
  assign limit = (words_in_use > bfa_pkg::LIMIT_MAX) ? bfa_pkg::LIMIT_MAX : words_in_use;

  assign cur_next   = cur + LW'(1);
  assign frame_word = frame[bfa_pkg::FRAME_W-1:BW];
  assign frame_bit  = WB'(1) << frame[BW-1:0];

  // Lowest clear bit of the word just read, as one-hot and as index
  assign word_full   = (ram_rdata == bfa_pkg::FULL_WORD);
  assign free_onehot = ~ram_rdata & (ram_rdata + WB'(1));

  always_comb begin
    free_idx = '0;
    for (int b = 0; b < WB; b++) begin
      if (free_onehot[b]) begin
        free_idx = free_idx | BW'(b);
      end
    end
  end

  // Read address: start of the item, or the word after the one under test
  always_comb begin
    ram_raddr = search_hint;
    if (state == ST_SCAN) begin
      ram_raddr = cur_next[AW-1:0];
    end else if (state == ST_IDLE) begin
      if (in_action == bfa_pkg::ACT_ALLOC) begin
        ram_raddr = search_hint;
      end else begin
        ram_raddr = in_frame[bfa_pkg::FRAME_W-1:BW];
      end
    end
  end

  // Write port: clear pass, whole-word load, read-modify-write, scan hit
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = clr_addr;
    ram_wdata = bfa_pkg::FULL_WORD;
    unique case (state)
      ST_CLEAR: begin
        ram_we = 1'b1;
      end
      ST_IDLE: begin
        ram_waddr = in_widx;
        ram_wdata = in_wval;
        ram_we    = accept && (in_action == bfa_pkg::ACT_LOAD);
      end
      ST_RMW: begin
        ram_waddr = frame_word;
        if (act == bfa_pkg::ACT_FREE) begin
          ram_wdata = ram_rdata & ~frame_bit;
          ram_we    = 1'b1;
        end else begin
          ram_wdata = ram_rdata | frame_bit;
          ram_we    = ((ram_rdata & frame_bit) == '0);
        end
      end
      ST_SCAN: begin
        ram_waddr = cur[AW-1:0];
        ram_wdata = ram_rdata | free_onehot;
        ram_we    = !word_full;
      end
      ST_RESP: begin
        ram_we = 1'b0;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      words_in_use <= bfa_pkg::LIMIT_MAX;
    end else if (cfg_valid && cfg_ready) begin
      words_in_use <= cfg_data;
    end
  end

  // Sequencer, allocator state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_CLEAR;
      clr_addr    <= '0;
      search_hint <= bfa_pkg::HINT_RESET;
      used_count  <= '0;
      m_tvalid    <= 1'b0;
    end else begin
      // Drop the result once taken, unless a new one is loaded below
      if (m_tvalid && m_tready && (state != ST_RESP)) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          // Sweep the bitmap to all used, one word a cycle
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == AW'(bfa_pkg::BITMAP_WORDS - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            act       <= bfa_pkg::action_t'(in_action);
            frame     <= in_frame;
            cur       <= LW'(search_hint);
            res_found <= '0;
            res_ok    <= 1'b0;
            unique case (bfa_pkg::action_t'(in_action))
              bfa_pkg::ACT_ALLOC: begin
                // Nothing to search when the hint is at or past the limit
                if (LW'(search_hint) < limit) begin
                  state <= ST_SCAN;
                end else begin
                  state <= ST_RESP;
                end
              end
              bfa_pkg::ACT_MARK, bfa_pkg::ACT_FREE: begin
                state <= ST_RMW;
              end
              bfa_pkg::ACT_LOAD: begin
                // Word written by the write port this cycle
                res_ok <= 1'b1;
                state  <= ST_RESP;
              end
              default: begin
                state <= ST_RESP;
              end
            endcase
          end
        end
        ST_RMW: begin
          if (act == bfa_pkg::ACT_FREE) begin
            res_ok <= 1'b1;
            if (used_count != '0) begin
              used_count <= used_count - 1'b1;
            end
            if (frame_word < search_hint) begin
              search_hint <= frame_word;
            end
          end else if ((ram_rdata & frame_bit) == '0) begin
            res_ok <= 1'b1;
            if (used_count != bfa_pkg::COUNT_MAX) begin
              used_count <= used_count + 1'b1;
            end
          end
          state <= ST_RESP;
        end
        ST_SCAN: begin
          if (!word_full) begin
            // Hit: bit set through the write port, move the hint here
            res_ok      <= 1'b1;
            res_found   <= {cur[AW-1:0], free_idx};
            search_hint <= cur[AW-1:0];
            if (used_count != bfa_pkg::COUNT_MAX) begin
              used_count <= used_count + 1'b1;
            end
            state <= ST_RESP;
          end else if (cur_next >= limit) begin
            state <= ST_RESP;
          end else begin
            // Next word is already being read
            cur <= cur_next;
          end
        end
        ST_RESP: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {used_count, res_found, res_ok};
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

>>> src/bfa_checker.sv
// ----------------------------------------------------------------------------
// bfa_checker
// Port-level checks of the bitmap page-frame allocator, bound to the top.
// ----------------------------------------------------------------------------
module bfa_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         s_tvalid,
  input logic                         s_tready,
  input logic                         m_tvalid,
  input logic                         m_tready,
  input logic [bfa_pkg::OUT_W-1:0]    m_tdata
);

  // Reset empties the output and starts the clearing pass
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !m_tvalid && !s_tready)
    else $error("output valid or input ready right after reset");

  // One word in flight: ready drops after every accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second input word accepted while one is in flight");

  // A failed action reports no frame
  a_fail_no_frame: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[0] |-> m_tdata[15:1] == '0)
    else $error("failed result carries a frame number");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed or dropped");

endmodule

bind bitmap_frame_allocator bfa_checker u_bfa_checker (.*);
